### rtl/escaped_line_lexer_defines.svh
// ----------------------------------------------------------------------------
// escaped_line_lexer_defines
// Assertion macros shared by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_LINE_LEXER_DEFINES_SVH
`define ESCAPED_LINE_LEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ELL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ELL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ell_pkg.sv
// ----------------------------------------------------------------------------
// ell_pkg
// Types and constants of the escaped line lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ell_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;

    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_FF   = 8'h0C;
    localparam logic [7:0] BYTE_BEL  = 8'h07;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    localparam logic [1:0] OCT_DIGITS_FULL = 2'd3;
    localparam logic [1:0] OCT_DIGITS_ONE  = 2'd1;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SKIP   = 3'd1,
        MODE_CLEAD  = 3'd2,
        MODE_CBODY  = 3'd3,
        MODE_ESC    = 3'd4,
        MODE_OCT    = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        KIND_LINE  = 3'd0,
        KIND_COMM  = 3'd1,
        KIND_EOL   = 3'd2,
        KIND_CLEAN = 3'd3,
        KIND_TRUNC = 3'd4,
        KIND_BAD   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [31:0] line_number;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

### rtl/escaped_line_lexer.sv
// ----------------------------------------------------------------------------
// escaped_line_lexer
// Splits a byte stream into logical lines: escapes, octal bytes, comments,
// line joins and line numbering, one source byte per cycle when not stalled.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one byte or an
// end-of-input mark per transaction. Each transaction yields zero, one or two
// results on the output channel (o_out_valid / i_out_ready, payload o_out);
// the last result of a transaction has last set.
// Results are registered in the result queue and reach o_out in order. At
// most one input transaction is taken per cycle, while at least two of the
// four result queue entries are free; a transaction that yields two results
// fills two entries. Configuration (i_cfg_valid / o_cfg_ready, i_cfg_data)
// loads the start line into both line counters and is always ready; the user
// must see that it is written only while idle; the block does not enforce
// this. Reset empties the queue, returns to normal mode and sets both line
// counters to 1. When the receiver stalls, results hold in the queue and
// o_in_ready drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_line_lexer_defines.svh"

module escaped_line_lexer
    import ell_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out
);

    t_mode               r_mode, n_mode;
    logic [8:0]          r_oct_val, n_oct_val;
    logic [1:0]          r_oct_digits, n_oct_digits;
    logic                r_lhb, n_lhb;
    logic [31:0]         r_logical, n_logical;
    logic [31:0]         r_physical, n_physical;

    t_out                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;

    logic                in_fire, out_fire;
    logic [7:0]          c;
    logic [31:0]         phys_inc;
    logic                c_octal;

    logic                nm_emit, nm_endl, nm_byte;
    t_mode               nm_mode;
    t_out                nm_res;

    logic [7:0]          esc_byte;
    logic                esc_known;
    logic [8:0]          oct_next;
    logic [1:0]          digits_next;

    t_out                res0, res1;
    logic [1:0]          res_cnt;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_in_ready  = r_count <= FIFO_CW'(FIFO_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out       = r_fifo[r_rd_ptr];

    assign c           = i_in.in_byte;
    assign phys_inc    = r_physical + 32'd1;
    assign c_octal     = c inside {[CH_ZERO:CH_SEVEN]};
    assign oct_next    = {r_oct_val[5:0], c[2:0]};
    assign digits_next = r_oct_digits + 2'd1;

    // normal-mode handling of the current byte
    always_comb begin
        nm_emit = 1'b0;
        nm_endl = 1'b0;
        nm_byte = 1'b0;
        nm_mode = MODE_NORMAL;
        nm_res  = '{kind: KIND_LINE, value: c, line_number: 32'd0, last: 1'b0};
        if (c == CH_BSLASH) begin
            nm_mode = MODE_ESC;
        end else if (c == CH_HASH) begin
            nm_mode = MODE_CLEAD;
        end else if (c == CH_NL) begin
            nm_emit = 1'b1;
            nm_endl = 1'b1;
            nm_res  = '{kind: KIND_EOL, value: 8'd0, line_number: r_logical, last: 1'b0};
        end else begin
            nm_emit = 1'b1;
            nm_byte = 1'b1;
        end
    end

    always_comb begin
        esc_known = 1'b1;
        case (c)
            CH_B:      esc_byte = BYTE_BS;
            CH_BSLASH: esc_byte = CH_BSLASH;
            CH_P:      esc_byte = CH_HASH;
            CH_F:      esc_byte = BYTE_FF;
            CH_A:      esc_byte = BYTE_BEL;
            CH_R:      esc_byte = BYTE_CR;
            CH_T:      esc_byte = CH_TAB;
            CH_N:      esc_byte = CH_NL;
            default: begin
                esc_byte  = c;
                esc_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode       = r_mode;
        n_oct_val    = r_oct_val;
        n_oct_digits = r_oct_digits;
        n_lhb        = r_lhb;
        n_logical    = r_logical;
        n_physical   = r_physical;
        res0         = '{kind: KIND_LINE, value: c, line_number: 32'd0, last: 1'b0};
        res1         = '{kind: KIND_LINE, value: c, line_number: 32'd0, last: 1'b0};
        res_cnt      = 2'd0;
        if (i_in.end_of_input) begin
            res0         = '{kind: (r_lhb ? KIND_TRUNC : KIND_CLEAN), value: 8'd0,
                             line_number: r_physical, last: 1'b0};
            res_cnt      = 2'd1;
            n_mode       = MODE_NORMAL;
            n_oct_val    = '0;
            n_oct_digits = '0;
            n_lhb        = 1'b0;
            n_logical    = r_physical;
        end else begin
            case (r_mode)
                MODE_NORMAL: begin
                    n_mode = nm_mode;
                    if (nm_endl) begin
                        n_physical = phys_inc;
                        n_logical  = phys_inc;
                        n_lhb      = 1'b0;
                    end
                    if (nm_byte) begin
                        n_lhb = 1'b1;
                    end
                    if (nm_emit) begin
                        res0    = nm_res;
                        res_cnt = 2'd1;
                    end
                end
                MODE_SKIP: begin
                    if (c == CH_NL) begin
                        n_physical = phys_inc;
                        n_mode     = MODE_NORMAL;
                    end
                end
                MODE_CLEAD, MODE_CBODY: begin
                    if (c == CH_NL) begin
                        n_physical = phys_inc;
                        n_logical  = phys_inc;
                        n_lhb      = 1'b0;
                        n_mode     = MODE_NORMAL;
                        res0       = nm_res;
                        res_cnt    = 2'd1;
                    end else if (r_mode == MODE_CBODY || (c != CH_SP && c != CH_TAB)) begin
                        n_mode  = MODE_CBODY;
                        res0    = '{kind: KIND_COMM, value: c, line_number: 32'd0, last: 1'b0};
                        res_cnt = 2'd1;
                    end
                end
                MODE_ESC: begin
                    if (c == CH_SP || c == CH_TAB) begin
                        n_mode = MODE_SKIP;
                    end else if (c == CH_NL) begin
                        n_physical = phys_inc;
                        n_mode     = MODE_NORMAL;
                    end else if (!esc_known && c_octal) begin
                        n_mode       = MODE_OCT;
                        n_oct_digits = OCT_DIGITS_ONE;
                        n_oct_val    = {6'd0, c[2:0]};
                    end else if (esc_known) begin
                        n_mode     = MODE_NORMAL;
                        n_lhb      = 1'b1;
                        res0.value = esc_byte;
                        res_cnt    = 2'd1;
                    end else begin
                        n_mode  = MODE_NORMAL;
                        n_lhb   = 1'b1;
                        res0    = '{kind: KIND_BAD, value: c, line_number: r_physical,
                                    last: 1'b0};
                        res_cnt = 2'd2;
                    end
                end
                default: begin
                    if (c_octal) begin
                        n_oct_val    = oct_next;
                        n_oct_digits = digits_next;
                        if (digits_next == OCT_DIGITS_FULL) begin
                            n_mode       = MODE_NORMAL;
                            n_oct_digits = '0;
                            n_lhb        = 1'b1;
                            res0.value   = oct_next[7:0];
                            res_cnt      = 2'd1;
                        end
                    end else begin
                        n_mode       = nm_mode;
                        n_oct_digits = '0;
                        n_lhb        = !nm_endl;
                        res0.value   = r_oct_val[7:0];
                        if (nm_endl) begin
                            n_physical = phys_inc;
                            n_logical  = phys_inc;
                        end
                        if (nm_emit) begin
                            res1    = nm_res;
                            res_cnt = 2'd2;
                        end else begin
                            res_cnt = 2'd1;
                        end
                    end
                end
            endcase
        end
        if (res_cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (res_cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_oct_val    <= '0;
            r_oct_digits <= '0;
            r_lhb        <= 1'b0;
            r_logical    <= 32'd1;
            r_physical   <= 32'd1;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_logical  <= i_cfg_data;
                r_physical <= i_cfg_data;
            end else if (in_fire) begin
                r_mode       <= n_mode;
                r_oct_val    <= n_oct_val;
                r_oct_digits <= n_oct_digits;
                r_lhb        <= n_lhb;
                r_logical    <= n_logical;
                r_physical   <= n_physical;
            end
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(res_cnt);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (in_fire ? FIFO_CW'(res_cnt) : FIFO_CW'(0))
                       - FIFO_CW'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_fire && res_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    `ELL_ASSERT_NOW(a_ready_room, i_clk, i_rst_n, o_in_ready,
        r_count <= FIFO_CW'(FIFO_DEPTH - 2), "input taken without room for two results")
    `ELL_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !in_fire && !out_fire,
        $stable(r_count), "queue count moved without a transaction")
    `ELL_ASSERT_NEXT(a_eoi_clear, i_clk, i_rst_n, in_fire && !i_cfg_valid && i_in.end_of_input,
        r_mode == MODE_NORMAL && !r_lhb && r_logical == r_physical,
        "end of input left lexer state behind")
    `ELL_ASSERT_NOW(a_byte_no_line, i_clk, i_rst_n,
        o_out_valid && (o_out.kind == KIND_LINE || o_out.kind == KIND_COMM),
        o_out.line_number == 32'd0, "byte result carries a line number")

endmodule

`default_nettype wire
